// ===== rtl/global_base_delta_word_encoder_defines.svh =====
// assertion macros for the global base delta word encoder, used by its serializer
// expects clk_i and rst_ni in the scope of every use
`ifndef GLOBAL_BASE_DELTA_WORD_ENCODER_DEFINES_SVH
`define GLOBAL_BASE_DELTA_WORD_ENCODER_DEFINES_SVH

// clocked check, off while in reset
`define GBDWE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form built on the plain check
`define GBDWE_ASSERT_IMPL(name, ante, cons, msg) \
  `GBDWE_ASSERT(name, (ante) |-> (cons), msg)

// next-cycle implication form
`define GBDWE_ASSERT_NEXT(name, ante, cons, msg) \
  `GBDWE_ASSERT(name, (ante) |=> (cons), msg)

`endif

// ===== rtl/gbdwe_pkg.sv =====
// shared types and constants for the global base delta word encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gbdwe_pkg;

  localparam int WORD_W        = 64;
  localparam int BYTE_W        = 8;
  localparam int VARINT_SHIFT  = 7;
  localparam int BASE_REGS     = 2;
  localparam int NUM_BASES_DEF = 2;
  localparam int CODE_W        = 3;   // holds base index plus one for up to seven bases
  localparam int CNT_W         = 2;
  localparam int REG_IDX_W     = 2;

  localparam logic [BYTE_W-1:0] VARINT_MORE = 8'h80;
  localparam logic [BYTE_W-1:0] VARINT_MASK = 8'h7F;

  localparam logic [REG_IDX_W-1:0] REG_BASE_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_0     = 2'd1;

  // word handed from the base select pipeline to the byte serializer
  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic [CODE_W-1:0] code;
    logic              fin;
  } enc_t;

endpackage

`default_nettype wire

// ===== rtl/global_base_delta_word_encoder.sv =====
// Global base delta word encoder. Each 64-bit word is compared against the enabled
// bases; the base giving the smallest strictly smaller difference wins, ties keep the
// lower index. The word leaves as a byte stream: one index byte (base index plus one,
// or 0 for none), then the difference or raw word as a little-endian base-128 varint.
// A word leaves as one index byte plus one value byte per 7 significant bits of the
// value from the byte-wide serializer, which can take the next word while it
// emits the last byte of the current one. Base selection runs as a pipeline of one
// subtract stage plus one compare stage per base register (three stages for two bases);
// it takes words back to back until it and the serializer's holding register are full.
// The first byte of a word passes through every pipeline stage, then the serializer's
// holding register and its byte output register before it is valid.
// Configuration: index 0 base_count, index 1 base_0, index 2 base_1; writes to other
// indexes are ignored.
// depends on gbdwe_pkg and gbdwe_ser
`timescale 1ns / 1ps
`default_nettype none

module global_base_delta_word_encoder
  import gbdwe_pkg::*;
#(
  parameter int NUM_BASES = NUM_BASES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [WORD_W-1:0]    s_axis_tdata_i,   // word
  input  wire logic                 s_axis_tlast_i,   // final_word
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [BYTE_W-1:0]         m_axis_tdata_o,   // out_byte
  output logic                      m_axis_tlast_o,   // last_byte
  output logic [1:0]                m_axis_tuser_o    // delta_part, block_end
);

  // bases past the register set are not built and can never win
  localparam int NREAL = (NUM_BASES < BASE_REGS) ? NUM_BASES : BASE_REGS;

  typedef struct packed {
    logic [WORD_W-1:0]             best;
    logic [CODE_W-1:0]             code;
    logic                          fin;
    logic [NREAL-1:0]              ok;
    logic [NREAL-1:0][WORD_W-1:0]  diff;
  } stg_t;

  logic [CNT_W-1:0]  base_count_q;
  logic [WORD_W-1:0] base_q [NREAL];

  stg_t             stg_q [NREAL+1];
  stg_t             stg_d [NREAL+1];
  logic [NREAL:0]   vld_q;
  logic [NREAL+1:0] rdy;
  logic             ser_ready;
  enc_t             enc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_count_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == REG_BASE_COUNT) begin
      base_count_q <= cfg_data_i[CNT_W-1:0];
    end
  end

  for (genvar k = 0; k < NREAL; k++) begin : g_base
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        base_q[k] <= '0;
      end else if (cfg_we_i && cfg_idx_i == REG_BASE_0 + REG_IDX_W'(k)) begin
        base_q[k] <= cfg_data_i;
      end
    end
  end

  // stage 0: differences and fit flags for every base
  always_comb begin
    logic [WORD_W:0] sub;
    stg_d[0]      = '0;
    stg_d[0].best = s_axis_tdata_i;
    stg_d[0].code = '0;
    stg_d[0].fin  = s_axis_tlast_i;
    for (int k = 0; k < NREAL; k++) begin
      sub              = {1'b0, s_axis_tdata_i} - {1'b0, base_q[k]};
      stg_d[0].diff[k] = sub[WORD_W-1:0];
      stg_d[0].ok[k]   = !sub[WORD_W] && (base_count_q > CNT_W'(k));
    end
  end

  // stage s: compare against base s-1, strictly smaller wins
  for (genvar s = 1; s <= NREAL; s++) begin : g_sel
    always_comb begin
      stg_d[s] = stg_q[s-1];
      if (stg_q[s-1].ok[s-1] && stg_q[s-1].diff[s-1] < stg_q[s-1].best) begin
        stg_d[s].best = stg_q[s-1].diff[s-1];
        stg_d[s].code = CODE_W'(s);
      end
    end
  end

  assign rdy[NREAL+1] = ser_ready;

  for (genvar s = 0; s <= NREAL; s++) begin : g_stage
    logic in_vld;
    if (s == 0) begin : g_first
      assign in_vld = s_axis_tvalid_i;
    end else begin : g_next
      assign in_vld = vld_q[s-1];
    end

    assign rdy[s] = !vld_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && in_vld) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  assign s_axis_tready_o = rdy[0];

  assign enc.val  = stg_q[NREAL].best;
  assign enc.code = stg_q[NREAL].code;
  assign enc.fin  = stg_q[NREAL].fin;

  gbdwe_ser u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (vld_q[NREAL]),
    .in_data_i       (enc),
    .in_ready_o      (ser_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== rtl/gbdwe_ser.sv =====
// byte serializer: turns one encoded word into index and value varint bytes
// depends on gbdwe_pkg and global_base_delta_word_encoder_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "global_base_delta_word_encoder_defines.svh"

module gbdwe_ser
  import gbdwe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire enc_t              in_data_i,
  output logic                   in_ready_o,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [BYTE_W-1:0]      m_axis_tdata_o,   // out_byte
  output logic                   m_axis_tlast_o,   // last_byte
  output logic [1:0]             m_axis_tuser_o    // delta_part, block_end
);

  logic              hold_vld_q;
  logic              phase_q;     // 0: index varint, 1: value varint
  logic [WORD_W-1:0] val_q;
  logic [CODE_W-1:0] code_q;
  logic              fin_q;

  logic              o_vld_q;
  logic [BYTE_W-1:0] o_byte_q;
  logic              o_part_q;
  logic              o_last_q;
  logic              o_end_q;

  logic              emit;
  logic              more;
  logic              done;
  logic [BYTE_W-1:0] byte_d;

  assign emit = hold_vld_q && (!o_vld_q || m_axis_tready_i);
  assign more = |val_q[WORD_W-1:VARINT_SHIFT];
  assign done = phase_q && !more;
  assign in_ready_o = !hold_vld_q || (emit && done);

  always_comb begin
    if (phase_q) begin
      byte_d = (val_q[BYTE_W-1:0] & VARINT_MASK) | (more ? VARINT_MORE : '0);
    end else begin
      // base index plus one is always below 128, so one byte
      byte_d = BYTE_W'(code_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      phase_q    <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      hold_vld_q <= 1'b1;
      phase_q    <= 1'b0;
    end else if (emit) begin
      hold_vld_q <= !done;
      phase_q    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      val_q  <= in_data_i.val;
      code_q <= in_data_i.code;
      fin_q  <= in_data_i.fin;
    end else if (emit && phase_q) begin
      val_q  <= val_q >> VARINT_SHIFT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (emit) begin
      o_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      o_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_byte_q <= byte_d;
      o_part_q <= phase_q;
      o_last_q <= done;
      o_end_q  <= done && fin_q;
    end
  end

  assign m_axis_tvalid_o = o_vld_q;
  assign m_axis_tdata_o  = o_byte_q;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tuser_o  = {o_end_q, o_part_q};

  `GBDWE_ASSERT_IMPL(a_last_in_value, o_vld_q && o_last_q, o_part_q, "last byte outside value varint")
  `GBDWE_ASSERT_IMPL(a_end_on_last, o_vld_q && o_end_q, o_last_q, "block end without last byte")
  `GBDWE_ASSERT_NEXT(a_index_then_value, emit && !phase_q, hold_vld_q && phase_q, "value varint lost after index byte")

endmodule

`default_nettype wire
